### src/stream_find_and_replace_unit_assert.svh
`ifndef STREAM_FIND_AND_REPLACE_UNIT_ASSERT_SVH
`define STREAM_FIND_AND_REPLACE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfr assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define SFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfr assertion failed");

`endif

### src/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

	localparam int unsigned PATTERN_MAX_DEF = 8;
	localparam int unsigned CFG_DATA_W      = 64;
	localparam int unsigned CFG_IDX_W       = 3;
	localparam int unsigned LEN_W           = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEARCH_PATTERN  = 3'd0,
		REG_SEARCH_LENGTH   = 3'd1,
		REG_REPLACE_PATTERN = 3'd2,
		REG_REPLACE_LENGTH  = 3'd3,
		REG_REPLACE_MODE    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
		logic       in_has_byte;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_has_byte;
		logic       out_last;
		logic       match_found;
	} out_word_t;

endpackage

`default_nettype wire

### src/stream_find_and_replace_unit.sv
// channel  | direction | handshake          | payload
// in       | input     | in_valid/in_stall  | sfr_pkg::in_word_t
// out      | output    | out_valid/out_stall| sfr_pkg::out_word_t
// cfg      | input     | cfg_write          | cfg_index, cfg_data
//
// a word is registered, then compared against the pattern and its results (0 to
// PATTERN_MAX) loaded into the result buffer, which drains one word per cycle unless
// out_stall is set. one input word per cycle while each word gives at most one result
// and out_stall is low; a word with more results holds the input until its last pops.
// out stall back-pressures the input register and then in_stall.
// reset loads config defaults and empties the input register, window and buffer.
`default_nettype none

`include "stream_find_and_replace_unit_assert.svh"

module stream_find_and_replace_unit #(
	parameter int unsigned PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [sfr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire sfr_pkg::in_word_t                in_data,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output sfr_pkg::out_word_t                    out_data
);
	import sfr_pkg::*;

	localparam int unsigned CW = $clog2(PATTERN_MAX + 1);

	// configuration
	logic [CFG_DATA_W-1:0] search_pat_q;
	logic [LEN_W-1:0]      search_len_q;
	logic [CFG_DATA_W-1:0] replace_pat_q;
	logic [LEN_W-1:0]      replace_len_q;
	logic                  replace_mode_q;

	// input register
	logic     valid_s1;
	in_word_t word_s1;

	// find state
	logic [7:0]    win_q [PATTERN_MAX];
	logic [CW-1:0] pend_cnt_q;
	logic          first_done_q;
	logic          any_q;

	// result buffer, head at entry 0
	out_word_t     buf_q [PATTERN_MAX];
	logic [CW-1:0] buf_cnt_q;

	logic          pop;
	logic          proc;
	logic          accept;

	logic [CW-1:0] slen;
	logic [CW-1:0] rlen;
	logic [7:0]    win2 [PATTERN_MAX];
	logic [CW-1:0] pc2;
	logic          do_cmp;
	logic          eq;
	logic          match;
	logic          any_new;
	logic [CW-1:0] drop;
	logic [CW-1:0] pc3;
	logic [CW-1:0] n_res;
	logic          bare;
	logic [7:0]    win3 [PATTERN_MAX];
	out_word_t     res [PATTERN_MAX];

	assign out_valid = (buf_cnt_q != '0);
	assign out_data  = buf_q[0];
	assign pop       = out_valid && !out_stall;
	assign proc      = valid_s1 &&
		((buf_cnt_q == '0) || ((buf_cnt_q == CW'(1)) && pop));
	assign in_stall  = valid_s1 && !proc;
	assign accept    = in_valid && !in_stall;

	always_comb begin
		// effective lengths
		if (search_len_q == '0) begin
			slen = CW'(1);
		end else if (32'(search_len_q) > PATTERN_MAX) begin
			slen = CW'(PATTERN_MAX);
		end else begin
			slen = CW'(search_len_q);
		end
		if (32'(replace_len_q) > PATTERN_MAX) begin
			rlen = CW'(PATTERN_MAX);
		end else begin
			rlen = CW'(replace_len_q);
		end

		// append the new byte
		pc2 = pend_cnt_q;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			win2[i] = win_q[i];
		end
		if (word_s1.in_has_byte && (32'(pend_cnt_q) < PATTERN_MAX)) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				if (CW'(i) == pend_cnt_q) begin
					win2[i] = word_s1.in_byte;
				end
			end
			pc2 = pend_cnt_q + CW'(1);
		end

		// compare window with the pattern
		do_cmp = (pc2 >= slen) && !(word_s1.in_last && (pc2 > slen));
		eq = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if ((CW'(i) < slen) && (win2[i] != search_pat_q[8*i +: 8])) begin
				eq = 1'b0;
			end
		end
		match   = do_cmp && eq && !(replace_mode_q && first_done_q);
		any_new = any_q || match;

		if (match) begin
			drop  = slen;
			n_res = rlen;
		end else if (do_cmp) begin
			drop  = CW'(1);
			n_res = word_s1.in_last ? pc2 : CW'(1);
		end else begin
			drop  = '0;
			n_res = word_s1.in_last ? pc2 : '0;
		end
		pc3 = pc2 - drop;

		// end with nothing to send gives a bare end marker
		bare = word_s1.in_last && (n_res == '0);
		if (bare) begin
			n_res = CW'(1);
		end

		for (int i = 0; i < PATTERN_MAX; i++) begin
			win3[i] = win2[i];
			for (int j = 0; j < PATTERN_MAX; j++) begin
				if (j == i + int'(drop)) begin
					win3[i] = win2[j];
				end
			end
		end

		for (int i = 0; i < PATTERN_MAX; i++) begin
			res[i].out_byte     = match ? replace_pat_q[8*i +: 8] : win2[i];
			res[i].out_has_byte = 1'b1;
			res[i].out_last     = word_s1.in_last && (CW'(i + 1) == n_res);
			res[i].match_found  = word_s1.in_last && (CW'(i + 1) == n_res) && any_new;
		end
		if (bare) begin
			res[0].out_byte     = '0;
			res[0].out_has_byte = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_pat_q   <= '0;
			search_len_q   <= LEN_W'(1);
			replace_pat_q  <= '0;
			replace_len_q  <= '0;
			replace_mode_q <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_SEARCH_PATTERN:  search_pat_q   <= cfg_data;
				REG_SEARCH_LENGTH:   search_len_q   <= cfg_data[LEN_W-1:0];
				REG_REPLACE_PATTERN: replace_pat_q  <= cfg_data;
				REG_REPLACE_LENGTH:  replace_len_q  <= cfg_data[LEN_W-1:0];
				REG_REPLACE_MODE:    replace_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q   <= '0;
			first_done_q <= 1'b0;
			any_q        <= 1'b0;
		end else if (proc) begin
			if (word_s1.in_last) begin
				pend_cnt_q   <= '0;
				first_done_q <= 1'b0;
				any_q        <= 1'b0;
			end else begin
				pend_cnt_q   <= pc3;
				first_done_q <= first_done_q || (match && replace_mode_q);
				any_q        <= any_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				win_q[i] <= win3[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= '0;
		end else if (proc) begin
			buf_cnt_q <= n_res;
		end else if (pop) begin
			buf_cnt_q <= buf_cnt_q - CW'(1);
		end
	end

	// load a fresh set of results or shift the head word out
	always_ff @(posedge clk) begin
		if (proc) begin
			for (int i = 0; i < PATTERN_MAX; i++) begin
				buf_q[i] <= res[i];
			end
		end else if (pop) begin
			for (int i = 0; i < PATTERN_MAX - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

	`SFR_ASSERT_IMPL(a_no_stall_when_empty, !valid_s1, !in_stall)
	`SFR_ASSERT_IMPL(a_last_is_final_word, out_valid && out_data.out_last, buf_cnt_q == CW'(1))
	`SFR_ASSERT_IMPL(a_status_only_on_last, out_valid && !out_data.out_last, !out_data.match_found)
	`SFR_ASSERT_NEXT(a_window_empty_after_last, proc && word_s1.in_last, pend_cnt_q == '0)

endmodule

`default_nettype wire
